### rtl/sdic_pkg.sv
package sdic_pkg;

  // Event kinds carried on in_tuser
  localparam logic [1:0] OP_VIDEO_RD = 2'd0;
  localparam logic [1:0] OP_CPU_TICK = 2'd1;
  localparam logic [1:0] OP_CPU_RD   = 2'd2;
  localparam logic [1:0] OP_CPU_WR   = 2'd3;

  localparam int unsigned ADDR_W = 16;
  localparam int unsigned DATA_W = 8;
  localparam int unsigned LINE_W = 8;

  // Remembered address is one bit wider so the reset value matches nothing
  localparam logic [ADDR_W:0]   ADDR_NONE   = 17'h1_FFFF;
  localparam logic [ADDR_W-1:0] NT_LOW      = 16'h2000;
  localparam logic [ADDR_W-1:0] NT_HIGH     = 16'h2FFF;
  localparam logic [ADDR_W-1:0] VEC_LO      = 16'hFFFA;
  localparam logic [ADDR_W-1:0] VEC_HI      = 16'hFFFB;
  localparam logic [ADDR_W-1:0] MASK_REG    = 16'h2001;
  localparam logic [DATA_W-1:0] RENDER_BITS = 8'h18;

  localparam logic [1:0]        REPEAT_MAX  = 2'd3;
  localparam logic [1:0]        REPEAT_HIT  = 2'd2;
  localparam logic [2:0]        IDLE_MAX    = 3'd7;
  localparam logic [2:0]        IDLE_END    = 3'd3;
  localparam logic [LINE_W-1:0] LINE_MAX    = 8'hFF;

  typedef struct packed {
    logic [ADDR_W:0]   prev_address;
    logic [1:0]        repeat_count;
    logic              frame_active;
    logic [LINE_W-1:0] line_counter;
    logic              pending_flag;
    logic [2:0]        idle_cycles;
    logic              video_seen;
  } state_t;

  localparam state_t STATE_RESET = '{
    prev_address: ADDR_NONE,
    repeat_count: 2'd0,
    frame_active: 1'b0,
    line_counter: '0,
    pending_flag: 1'b0,
    idle_cycles:  3'd0,
    video_seen:   1'b0
  };

endpackage

### rtl/sdic_step.sv
module sdic_step (
  input  sdic_pkg::state_t                    cur_state,
  input  logic [1:0]                          op,
  input  logic [sdic_pkg::ADDR_W-1:0]         bus_address,
  input  logic [sdic_pkg::DATA_W-1:0]         write_data,
  input  logic [sdic_pkg::LINE_W-1:0]         line_compare,
  output sdic_pkg::state_t                    nxt_state
);
  import sdic_pkg::*;

  logic              nt_hit;
  logic [1:0]        rep_inc;
  logic [LINE_W-1:0] line_inc;
  logic [2:0]        idle_inc;

  assign nt_hit = (bus_address >= NT_LOW) && (bus_address <= NT_HIGH) &&
                  ({1'b0, bus_address} == cur_state.prev_address);
  assign rep_inc  = (cur_state.repeat_count < REPEAT_MAX) ?
                    cur_state.repeat_count + 2'd1 : cur_state.repeat_count;
  assign line_inc = (cur_state.line_counter != LINE_MAX) ?
                    cur_state.line_counter + {{(LINE_W-1){1'b0}}, 1'b1} :
                    cur_state.line_counter;
  assign idle_inc = cur_state.idle_cycles + 3'd1;

  always_comb begin
    nxt_state = cur_state;
    unique case (op)
      OP_VIDEO_RD: begin
        if (nt_hit) begin
          nxt_state.repeat_count = rep_inc;
          if (rep_inc == REPEAT_HIT) begin
            if (!cur_state.frame_active) begin
              // first scanline of a frame
              nxt_state.frame_active = 1'b1;
              nxt_state.line_counter = '0;
            end else begin
              nxt_state.line_counter = line_inc;
              if (line_inc == line_compare) nxt_state.pending_flag = 1'b1;
            end
          end
        end else begin
          nxt_state.repeat_count = 2'd0;
        end
        nxt_state.prev_address = {1'b0, bus_address};
        nxt_state.video_seen   = 1'b1;
      end
      OP_CPU_TICK: begin
        if (cur_state.video_seen) begin
          nxt_state.idle_cycles = 3'd0;
        end else if (cur_state.idle_cycles < IDLE_MAX) begin
          nxt_state.idle_cycles = idle_inc;
          if (idle_inc == IDLE_END) begin
            nxt_state.frame_active = 1'b0;
            nxt_state.prev_address = ADDR_NONE;
          end
        end
        nxt_state.video_seen = 1'b0;
      end
      OP_CPU_RD: begin
        if ((bus_address == VEC_LO) || (bus_address == VEC_HI)) begin
          nxt_state.frame_active = 1'b0;
          nxt_state.prev_address = ADDR_NONE;
        end
      end
      OP_CPU_WR: begin
        if ((bus_address == MASK_REG) && ((write_data & RENDER_BITS) == '0)) begin
          nxt_state.frame_active = 1'b0;
          nxt_state.prev_address = ADDR_NONE;
        end
      end
      default: nxt_state = cur_state;
    endcase
  end

endmodule

### rtl/scanline_detect_irq_counter_unit.sv
// Scanline detector with scanline interrupt counter.
//
// Input stream: one bus event per transfer. in_tuser carries the event kind
// (video read, cpu tick, cpu read, cpu write); in_tdata carries the address
// and the cpu write byte. Every accepted event yields exactly one result
// transfer on the out_ stream with the interrupt pending flag, the in-frame
// flag and the current scanline count as they stand after that event.
// The compare register is written through cfg_wr_en / cfg_wr_data; the user
// must write it only while the stream is quiet, the block does not enforce it.
//
// An accepted event goes through the input register, then the state update
// into the result register, before it is presented on out_tvalid.
// Throughput: one event per clock while the receiver does not stall; the
// only loop is the state update through the single state register.
//
// Reset (rst_n low, synchronous) empties both registers, clears all
// detector state, forgets the last address and zeroes the compare value.
// When the receiver stalls, the result stays in the output register; the
// input register still takes one more event, then in_tready drops.
module scanline_detect_irq_counter_unit (
  input  logic        clk,
  input  logic        rst_n,
  // event stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [15:0] bus_address, [23:16] write_data
  input  logic [1:0]  in_tuser,   // [1:0] op
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [0] irq_pending, [1] in_frame,
                                  // [9:2] line_number, [15:10] zero
  // compare register
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);
  import sdic_pkg::*;

  // input register
  logic                in_valid_r;
  logic [1:0]          op_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [DATA_W-1:0]   wdata_r;

  // detector state and compare
  state_t              state_r;
  state_t              state_nxt;
  logic [LINE_W-1:0]   line_compare_r;

  // result register
  logic                out_valid_r;
  logic [15:0]         out_data_r;

  logic                advance;

  // the event moves into the result register when that register is free
  // or being drained in the same cycle
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r    <= in_tuser;
      addr_r  <= in_tdata[ADDR_W-1:0];
      wdata_r <= in_tdata[ADDR_W+DATA_W-1:ADDR_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_compare_r <= '0;
    end else if (cfg_wr_en) begin
      line_compare_r <= cfg_wr_data;
    end
  end

  sdic_step u_step (
    .cur_state    (state_r),
    .op           (op_r),
    .bus_address  (addr_r),
    .write_data   (wdata_r),
    .line_compare (line_compare_r),
    .nxt_state    (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RESET;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= {6'd0, state_nxt.line_counter, state_nxt.frame_active,
                     state_nxt.pending_flag};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // pending flag has no acknowledge
  a_pending_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.pending_flag |=> state_r.pending_flag)
    else $error("irq pending flag cleared without reset");

  // detector state only moves when an event is retired
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(state_r))
    else $error("detector state changed without an event");

  // a new frame always starts from scanline zero
  a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r.frame_active) |-> (state_r.line_counter == '0))
    else $error("frame started with nonzero line count");

  // the flag is only raised inside a frame
  a_pending_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r.pending_flag) |-> state_r.frame_active)
    else $error("irq pending raised outside a frame");

  // a forgotten address never counts as a repeat
  a_none_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && (op_r == OP_VIDEO_RD) && (state_r.prev_address == ADDR_NONE))
      |=> (state_r.repeat_count == 2'd0))
    else $error("repeat counted after frame end");

endmodule

### sim/scanline_irq_checker.sv
`timescale 1ns / 100ps

// Watches both streams and the compare register port. Keeps its own copy of
// the detector state, works out the status after every accepted event and
// compares it with the result transfers in order.
module scanline_irq_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  output logic [31:0] fail_count,
  output logic [31:0] status_pending
);
  import sdic_pkg::*;

  typedef struct packed {
    logic              irq;
    logic              frame;
    logic [LINE_W-1:0] line;
  } line_status_t;

  line_status_t status_q[$];
  int unsigned  n_fail = 0;

  logic [ADDR_W:0]   last_addr;
  logic [1:0]        repeat_run;
  logic              frame_on;
  logic [LINE_W-1:0] line_cnt;
  logic              irq_flag;
  logic [2:0]        idle_run;
  logic              video_hit;
  logic [LINE_W-1:0] cmp_value;

  assign fail_count = n_fail;

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("ERROR %0t: %s: got %h, expected %h", $time, what, got, want);
    n_fail++;
  endtask

  task automatic drop_frame();
    frame_on  = 1'b0;
    last_addr = ADDR_NONE;
  endtask

  task automatic advance_detector(input logic [1:0] op, input logic [ADDR_W-1:0] addr,
                                  input logic [DATA_W-1:0] data);
    case (op)
      OP_VIDEO_RD: begin
        if (addr >= NT_LOW && addr <= NT_HIGH && {1'b0, addr} == last_addr) begin
          if (repeat_run != REPEAT_MAX) repeat_run = repeat_run + 2'd1;
          // only the step onto the second repeat counts as a scanline
          if (repeat_run == REPEAT_HIT) begin
            if (!frame_on) begin
              frame_on = 1'b1;
              line_cnt = '0;
            end else begin
              if (line_cnt != LINE_MAX) line_cnt = line_cnt + 8'd1;
              if (line_cnt == cmp_value) irq_flag = 1'b1;
            end
          end
        end else begin
          repeat_run = 2'd0;
        end
        last_addr = {1'b0, addr};
        video_hit = 1'b1;
      end
      OP_CPU_TICK: begin
        if (video_hit) begin
          idle_run = 3'd0;
        end else if (idle_run != IDLE_MAX) begin
          idle_run = idle_run + 3'd1;
          if (idle_run == IDLE_END) drop_frame();
        end
        video_hit = 1'b0;
      end
      OP_CPU_RD: begin
        if (addr == VEC_LO || addr == VEC_HI) drop_frame();
      end
      OP_CPU_WR: begin
        if (addr == MASK_REG && (data & RENDER_BITS) == '0) drop_frame();
      end
      default: ;
    endcase
  endtask

  task automatic check_result(input logic [15:0] got);
    line_status_t want;
    if (status_q.size() == 0) begin
      report_mismatch("result with nothing outstanding", got, 16'h0);
    end else begin
      want = status_q.pop_front();
      if (got[0] !== want.irq)
        report_mismatch("irq_pending", 16'(got[0]), 16'(want.irq));
      if (got[1] !== want.frame)
        report_mismatch("in_frame", 16'(got[1]), 16'(want.frame));
      if (got[9:2] !== want.line)
        report_mismatch("line_number", 16'(got[9:2]), 16'(want.line));
      if (got[15:10] !== 6'd0)
        report_mismatch("tdata pad bits", 16'(got[15:10]), 16'h0);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      last_addr  = ADDR_NONE;
      repeat_run = 2'd0;
      frame_on   = 1'b0;
      line_cnt   = '0;
      irq_flag   = 1'b0;
      idle_run   = 3'd0;
      video_hit  = 1'b0;
      cmp_value  = '0;
      status_q.delete();
      status_pending <= '0;
    end else begin
      if (cfg_wr_en) cmp_value = cfg_wr_data;
      if (out_tvalid && out_tready) check_result(out_tdata);
      if (in_tvalid && in_tready) begin
        advance_detector(in_tuser, in_tdata[15:0], in_tdata[23:16]);
        status_q.push_back(line_status_t'{irq: irq_flag, frame: frame_on, line: line_cnt});
      end
      status_pending <= status_q.size();
    end
  end

endmodule

### sim/scanline_detect_irq_counter_unit_tb.sv
`timescale 1ns / 100ps

module scanline_detect_irq_counter_unit_tb;
  import sdic_pkg::*;

  // Run is cut off here if the result stream stops draining.
  localparam int unsigned RUN_LIMIT_NS = 5_000_000;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata    = '0;   // [15:0] bus_address, [23:16] write_data
  logic [1:0]  in_tuser    = '0;   // [1:0] op
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [15:0] out_tdata;          // [0] irq_pending, [1] in_frame, [9:2] line_number
  logic        cfg_wr_en   = 1'b0;
  logic [7:0]  cfg_wr_data = '0;

  logic [31:0] fail_count;
  logic [31:0] status_pending;

  int unsigned events_sent = 0;
  int unsigned burst_left  = 0;

  // receiver stall pattern state
  int unsigned rdy_mode  = 0;
  int unsigned rdy_left  = 0;
  logic [7:0]  rdy_phase = '0;

  scanline_detect_irq_counter_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  scanline_irq_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .fail_count     (fail_count),
    .status_pending (status_pending)
  );

  always #5 clk = ~clk;

  // Receiver: switches between stall modes when its random countdown runs out.
  //   0 always ready, 1 coin flip, 2 one stall in four, 3 mostly stalled
  always @(posedge clk) begin
    if (rdy_left == 0) begin
      rdy_mode <= $urandom_range(0, 3);
      rdy_left <= $urandom_range(20, 300);
    end else begin
      rdy_left <= rdy_left - 1;
    end
    rdy_phase <= rdy_phase + 8'd1;
    case (rdy_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 1) == 1);
      2:       out_tready <= (rdy_phase[1:0] != 2'd3);
      default: out_tready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  // One event transfer. Bursts of random length, random gaps between them.
  // Returns at the edge where the transfer happened.
  task automatic send_event(input logic [1:0] op, input logic [15:0] addr,
                            input logic [7:0] data);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      // now and then a long unbroken stretch
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {data, addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    events_sent++;
  endtask

  // Stop sending and wait until every predicted status has come back,
  // then wait for the two register stages to go quiet.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (status_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_line_compare(input logic [7:0] value);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic logic [15:0] pick_nametable();
    return NT_LOW + 16'($urandom_range(0, 'hFFF));
  endfunction

  // A run of scanlines: each line is a repeated fetch of one nametable
  // address. Sparse mode mixes in ticks, short (broken) lines and harmless
  // cpu accesses; dense mode is exactly three reads per line.
  task automatic run_frame(input int n_lines, input bit dense);
    logic [15:0] nt;
    int          reads;
    for (int i = 0; i < n_lines; i++) begin
      nt = pick_nametable();
      if (dense)
        reads = 3;
      else if ($urandom_range(0, 7) == 0)
        reads = $urandom_range(1, 2);
      else
        reads = $urandom_range(3, 5);
      for (int k = 0; k < reads; k++) begin
        send_event(OP_VIDEO_RD, nt, 8'($urandom));
        if (!dense && $urandom_range(0, 3) == 0)
          send_event(OP_CPU_TICK, 16'($urandom), 8'($urandom));
      end
      if (!dense) begin
        case ($urandom_range(0, 5))
          0: send_event(OP_CPU_TICK, 16'($urandom), 8'($urandom));
          1: repeat (2) send_event(OP_CPU_TICK, 16'($urandom), 8'($urandom));
          2: send_event(OP_CPU_RD, 16'($urandom), 8'($urandom));
          // mask write that keeps rendering on
          3: send_event(OP_CPU_WR, MASK_REG, 8'($urandom) | (8'h08 << $urandom_range(0, 1)));
          default: ;
        endcase
      end
    end
  endtask

  // Close the frame one of three ways, or let it carry on.
  task automatic close_frame();
    case ($urandom_range(0, 3))
      0: repeat ($urandom_range(3, 9)) send_event(OP_CPU_TICK, 16'($urandom), 8'($urandom));
      1: send_event(OP_CPU_RD, $urandom_range(0, 1) ? VEC_HI : VEC_LO, 8'($urandom));
      2: send_event(OP_CPU_WR, MASK_REG, 8'($urandom) & ~RENDER_BITS);
      default: ;
    endcase
  endtask

  // Unstructured events over the whole field ranges, biased toward the
  // addresses the detector cares about.
  task automatic send_noise();
    logic [15:0] addr;
    repeat ($urandom_range(4, 16)) begin
      case ($urandom_range(0, 5))
        0: addr = pick_nametable();
        1: addr = VEC_LO;
        2: addr = VEC_HI;
        3: addr = MASK_REG;
        default: addr = 16'($urandom);
      endcase
      send_event(2'($urandom_range(0, 3)), addr, 8'($urandom));
    end
  endtask

  task automatic run_mix(input int unsigned target, input int max_lines);
    while (events_sent < target) begin
      if ($urandom_range(0, 9) < 8) begin
        run_frame($urandom_range(1, max_lines), 1'b0);
        close_frame();
      end else begin
        send_noise();
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed, compare still at its reset value of zero ----
    // three fetches of one address: frame starts at line 0
    repeat (3) send_event(OP_VIDEO_RD, NT_LOW, 8'h00);
    // fourth fetch only pushes the repeat count into saturation
    send_event(OP_VIDEO_RD, NT_LOW, 8'hFF);
    // top of the nametable window: line 1, compare of zero never fires
    repeat (3) send_event(OP_VIDEO_RD, NT_HIGH, 8'h00);
    // tick fields are don't-care
    send_event(OP_CPU_TICK, 16'hFFFF, 8'hFF);
    // just outside the window: no scanline
    repeat (3) send_event(OP_VIDEO_RD, NT_LOW - 16'd1, 8'h00);
    send_event(OP_CPU_RD, VEC_HI, 8'h00);              // vector read ends frame
    repeat (3) send_event(OP_VIDEO_RD, NT_HIGH, 8'h00); // new frame, line cleared
    send_event(OP_CPU_WR, MASK_REG, RENDER_BITS);        // rendering still on
    send_event(OP_CPU_WR, MASK_REG, ~RENDER_BITS);       // rendering off
    send_event(OP_CPU_WR, 16'h5203, 8'hFF);              // no acknowledge here
    repeat (3) send_event(OP_VIDEO_RD, NT_LOW + 16'd1, 8'h00);
    send_event(OP_CPU_RD, VEC_LO, 8'hFF);
    repeat (3) send_event(OP_VIDEO_RD, NT_LOW, 8'h00);
    // idle ticks: frame ends on the third idle one, counter saturates at 7
    repeat (10) send_event(OP_CPU_TICK, 16'h0000, 8'h00);

    // ---- compare 0: the flag must never rise ----
    load_line_compare(8'd0);
    run_mix(200, 12);
    drain_results();   // sender holds until the result stream is empty
    run_mix(330, 12);

    // ---- compare 255 with short frames ----
    load_line_compare(8'd255);
    run_mix(620, 12);

    // ---- low compare, so the flag rises on an exact match ----
    load_line_compare(8'd9);
    run_mix(900, 14);

    // ---- one long frame: counter saturates, compare 255 keeps matching ----
    load_line_compare(8'd255);
    send_event(OP_CPU_RD, VEC_LO, 8'h00);
    run_frame(258, 1'b1);
    run_mix(1760, 10);

    // ---- random compare ----
    load_line_compare(8'($urandom_range(1, 254)));
    run_mix(1900, 12);

    drain_results();
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Some tests failed");
    $finish;
  end

endmodule
